[sv/udiv_pkg.sv]
// Shared widths and word types for the 64-by-32 divider.
`default_nettype none
package udiv_pkg;

    localparam int DIVIDEND_W      = 64;
    localparam int DIVISOR_W       = 32;
    localparam int STAGE_STEPS_DEF = 1;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } udiv_in_t;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
        logic                  div_by_zero;
    } udiv_out_t;

    // nq: remaining dividend bits on top, quotient bits entering at the bottom
    typedef struct packed {
        logic [DIVIDEND_W-1:0] nq;
        logic [DIVISOR_W-1:0]  part;
        logic [DIVISOR_W-1:0]  den;
        logic                  dbz;
    } udiv_work_t;

endpackage
`default_nettype wire

[sv/udiv_stage.sv]
// One pipeline stage of the restoring divider: STAGE_STEPS shift-and-subtract steps.
`default_nettype none
module udiv_stage #(
    parameter int STAGE_STEPS = udiv_pkg::STAGE_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               src_valid,
    input  udiv_pkg::udiv_work_t    src_work,
    output logic                    valid,
    output udiv_pkg::udiv_work_t    work
);
    import udiv_pkg::*;

    logic                  valid_reg;
    udiv_work_t            work_reg;
    udiv_work_t            work_next;
    logic [DIVIDEND_W-1:0] nq;
    logic [DIVISOR_W-1:0]  part;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;

    always_comb
    begin
        nq      = src_work.nq;
        part    = src_work.part;
        shifted = '0;
        diff    = '0;
        ge      = 1'b0;
        for (int i = 0; i < STAGE_STEPS; i++)
        begin
            shifted = {part, nq[DIVIDEND_W-1]};
            diff    = {1'b0, shifted} - {2'b00, src_work.den};
            ge      = !diff[DIVISOR_W+1];
            part    = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            nq      = {nq[DIVIDEND_W-2:0], ge};
        end
        work_next      = src_work;
        work_next.nq   = nq;
        work_next.part = part;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign valid = valid_reg;
    assign work  = work_reg;

endmodule
`default_nettype wire

[sv/udiv_64_by_32_core.sv]
// Top level of the pipelined unsigned 64-by-32 restoring divider.
//
// Input channel: in_valid / in_stall carry a word with dividend and divisor.
// Output channel: out_valid / out_stall carry quotient, remainder, div_by_zero.
// A zero divisor returns zero quotient and remainder with div_by_zero set.
// The work runs through DIVIDEND_W / STAGE_STEPS register stages, each doing
// STAGE_STEPS shift-and-subtract steps on a 32-bit partial remainder, and then
// one output register. A word passes through all the stage registers and then the
// output register, and one word can enter every cycle while no output word is
// held by out_stall, so throughput is one word per cycle.
// A stalled output word holds the whole pipeline in place: in_stall rises
// together with out_stall while an output word waits, and nothing is lost or
// repeated. Reset clears all valid bits; the pipeline is then empty and ready.
`default_nettype none
module udiv_64_by_32_core #(
    parameter int STAGE_STEPS = udiv_pkg::STAGE_STEPS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  udiv_pkg::udiv_in_t   in_word,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output udiv_pkg::udiv_out_t  out_word
);
    import udiv_pkg::*;

    localparam int NUM_STAGES = DIVIDEND_W / STAGE_STEPS;

    logic       en;
    logic       stage_valid [NUM_STAGES];
    udiv_work_t stage_work  [NUM_STAGES];
    udiv_work_t entry_work;
    logic       out_valid_reg;
    udiv_out_t  out_reg;
    udiv_out_t  out_next;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    always_comb
    begin
        entry_work.nq   = in_word.dividend;
        entry_work.part = '0;
        entry_work.den  = in_word.divisor;
        entry_work.dbz  = (in_word.divisor == '0);
    end

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            udiv_stage #(
                .STAGE_STEPS (STAGE_STEPS)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .src_valid (in_valid),
                .src_work  (entry_work),
                .valid     (stage_valid[s]),
                .work      (stage_work[s])
            );
        end
        else
        begin : g_next
            udiv_stage #(
                .STAGE_STEPS (STAGE_STEPS)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .src_valid (stage_valid[s-1]),
                .src_work  (stage_work[s-1]),
                .valid     (stage_valid[s]),
                .work      (stage_work[s])
            );
        end
    end

    // drop results to zero on divide by zero
    always_comb
    begin
        out_next.div_by_zero = stage_work[NUM_STAGES-1].dbz;
        if (stage_work[NUM_STAGES-1].dbz)
        begin
            out_next.quotient  = '0;
            out_next.remainder = '0;
        end
        else
        begin
            out_next.quotient  = stage_work[NUM_STAGES-1].nq;
            out_next.remainder = stage_work[NUM_STAGES-1].part;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage_valid[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`ifndef SYNTHESIS
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.div_by_zero) |->
            (out_word.quotient == '0 && out_word.remainder == '0))
        else $error("div_by_zero word with nonzero result");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[NUM_STAGES-1] && !stage_work[NUM_STAGES-1].dbz) |->
            (stage_work[NUM_STAGES-1].part < stage_work[NUM_STAGES-1].den))
        else $error("final remainder not below divisor");

    a_dbz_flag: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[0] |-> (stage_work[0].dbz == (stage_work[0].den == '0)))
        else $error("zero-divisor flag does not match divisor");
`endif

endmodule
`default_nettype wire

[test/udiv_checker.sv]
// Checker for the 64-by-32 divider: watches both channels, predicts and compares each word.
`default_nettype none
module udiv_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_stall,
    input  udiv_pkg::udiv_in_t  in_word,
    input  wire logic          out_valid,
    input  wire logic          out_stall,
    input  udiv_pkg::udiv_out_t out_word,
    output int                 mismatches,
    output int                 pending
);
    import udiv_pkg::*;

    udiv_out_t due_results[$];
    udiv_out_t want;

    function automatic udiv_out_t divide_word(udiv_in_t w);
        udiv_out_t       res;
        logic [32:0]     part;
        logic [63:0]     quo;
        int              i;
        res = '0;
        if (w.divisor == '0)
        begin
            res.div_by_zero = 1'b1;
            return res;
        end
        part = '0;
        quo  = '0;
        for (i = DIVIDEND_W - 1; i >= 0; i--)
        begin
            part = {part[31:0], w.dividend[i]};
            quo  = quo << 1;
            if (part >= {1'b0, w.divisor})
            begin
                part   = part - {1'b0, w.divisor};
                quo[0] = 1'b1;
            end
        end
        res.quotient  = quo;
        res.remainder = part[31:0];
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(divide_word(in_word));
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected word: quotient %h remainder %h div_by_zero %b",
                           out_word.quotient, out_word.remainder, out_word.div_by_zero);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_word.quotient !== want.quotient)
                    begin
                        $error("quotient: expected %h, got %h",
                               want.quotient, out_word.quotient);
                        mismatches++;
                    end
                    if (out_word.remainder !== want.remainder)
                    begin
                        $error("remainder: expected %h, got %h",
                               want.remainder, out_word.remainder);
                        mismatches++;
                    end
                    if (out_word.div_by_zero !== want.div_by_zero)
                    begin
                        $error("div_by_zero: expected %b, got %b",
                               want.div_by_zero, out_word.div_by_zero);
                        mismatches++;
                    end
                end
            end
        end
        pending = due_results.size();
    end

endmodule
`default_nettype wire

[test/tb_top.sv]
// Testbench top for the 64-by-32 divider: clock, reset, stimulus and verdict.
`default_nettype none
module tb_top;
    import udiv_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    udiv_in_t  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    udiv_out_t out_word;
    int        mismatches;
    int        pending;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    udiv_64_by_32_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    udiv_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 200000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send_word(input udiv_in_t w);
        logic stalled;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    task automatic send_pair(input logic [63:0] num, input logic [31:0] den);
        udiv_in_t w;
        w.dividend = num;
        w.divisor  = den;
        send_word(w);
    endtask

    function automatic udiv_in_t rand_word();
        udiv_in_t w;
        w.dividend = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       w.divisor = '0;
            1:       w.divisor = $urandom_range(1, 15);
            2:       w.divisor = 32'h1 << $urandom_range(0, 31);
            3:       w.divisor = 32'hFFFF_FFFF - $urandom_range(0, 15);
            4:       w.divisor = $urandom >> $urandom_range(0, 31);
            default: w.divisor = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0: w.dividend = w.dividend >> $urandom_range(1, 63);
            1: w.dividend = {32'h0, $urandom};
            2: w.dividend = 64'(w.divisor) * 64'($urandom)
                            + (w.divisor == '0 ? 64'h0 : 64'(w.divisor - 32'h1));
            3: w.dividend = 64'(w.divisor) * 64'($urandom);
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(64'h0, 32'h0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_pair(64'h1234_5678_9ABC_DEF0, 32'h0);
        send_pair(64'h0, 32'h1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h2);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
        send_pair(64'h8000_0000_0000_0000, 32'h8000_0000);
        send_pair(64'h0000_0001_0000_0000, 32'hFFFF_FFFF);
        send_pair(64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(64'h0000_0000_0000_0001, 32'hFFFF_FFFF);
        send_pair(64'h0000_0000_FFFF_FFFE, 32'hFFFF_FFFF);
        send_pair(64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(64'h0000_0000_0000_0005, 32'h3);
        send_pair(64'h0000_0000_0000_0003, 32'h5);
        send_pair(64'h1234_5678_9ABC_DEF0, 32'h0001_2345);
        send_pair(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        send_pair(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        send_pair(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            repeat (238) send_word(rand_word());
        end
        in_valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
sv/udiv_pkg.sv
sv/udiv_stage.sv
sv/udiv_64_by_32_core.sv
test/udiv_checker.sv
test/tb_top.sv
